FILE: hw/rtl/dwe_pkg.sv
// Shared types, opcode and error constants for the DWARF expression stack machine.
// No dependencies; the top level dwarf_expression_stack_machine imports this package.
package dwe_pkg;

    localparam logic [7:0] OP_ADDR        = 8'h03;
    localparam logic [7:0] OP_CONST1U     = 8'h08;
    localparam logic [7:0] OP_CONSTS      = 8'h11;
    localparam logic [7:0] OP_DUP         = 8'h12;
    localparam logic [7:0] OP_DROP        = 8'h13;
    localparam logic [7:0] OP_OVER        = 8'h14;
    localparam logic [7:0] OP_PICK        = 8'h15;
    localparam logic [7:0] OP_SWAP        = 8'h16;
    localparam logic [7:0] OP_ROT         = 8'h17;
    localparam logic [7:0] OP_ABS         = 8'h19;
    localparam logic [7:0] OP_AND         = 8'h1a;
    localparam logic [7:0] OP_DIV         = 8'h1b;
    localparam logic [7:0] OP_MINUS       = 8'h1c;
    localparam logic [7:0] OP_MUL         = 8'h1e;
    localparam logic [7:0] OP_NEG         = 8'h1f;
    localparam logic [7:0] OP_OR          = 8'h21;
    localparam logic [7:0] OP_PLUS        = 8'h22;
    localparam logic [7:0] OP_PLUS_UCONST = 8'h23;
    localparam logic [7:0] OP_SHL         = 8'h24;
    localparam logic [7:0] OP_SHR         = 8'h25;
    localparam logic [7:0] OP_XOR         = 8'h27;
    localparam logic [7:0] OP_EQ          = 8'h29;
    localparam logic [7:0] OP_GE          = 8'h2a;
    localparam logic [7:0] OP_GT          = 8'h2b;
    localparam logic [7:0] OP_LE          = 8'h2c;
    localparam logic [7:0] OP_LT          = 8'h2d;
    localparam logic [7:0] OP_NE          = 8'h2e;
    localparam logic [7:0] OP_LIT0        = 8'h30;
    localparam logic [7:0] OP_LIT31       = 8'h4f;
    localparam logic [7:0] OP_NOP         = 8'h96;
    localparam logic [7:0] OP_STACK_VALUE = 8'h9f;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_UNDER = 3'd1;
    localparam logic [2:0] ERR_OVER  = 3'd2;
    localparam logic [2:0] ERR_UNSUP = 3'd3;
    localparam logic [2:0] ERR_DIV0  = 3'd4;

    typedef enum logic [3:0] {
        CL_LIT, CL_OPND, CL_DROP, CL_DUP, CL_PICK, CL_OVER, CL_SWAP, CL_ROT,
        CL_ABS, CL_NEG, CL_BIN, CL_PLUSU, CL_STACKVAL, CL_NOP, CL_UNSUP
    } t_opclass;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_RD1, ST_RD2, ST_EXEC, ST_MULDIV, ST_WR2, ST_FIN
    } t_state;

    function automatic t_opclass f_classify(input logic [7:0] mode);
        t_opclass cls;
        begin
            cls = CL_UNSUP;
            if (mode >= OP_LIT0 && mode <= OP_LIT31) begin
                cls = CL_LIT;
            end else if (mode == OP_ADDR || (mode >= OP_CONST1U && mode <= OP_CONSTS)) begin
                cls = CL_OPND;
            end else begin
                unique case (mode)
                    OP_DROP:        cls = CL_DROP;
                    OP_DUP:         cls = CL_DUP;
                    OP_PICK:        cls = CL_PICK;
                    OP_OVER:        cls = CL_OVER;
                    OP_SWAP:        cls = CL_SWAP;
                    OP_ROT:         cls = CL_ROT;
                    OP_ABS:         cls = CL_ABS;
                    OP_NEG:         cls = CL_NEG;
                    OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_PLUS, OP_MINUS, OP_MUL,
                    OP_DIV, OP_EQ, OP_GE, OP_GT, OP_LE, OP_LT, OP_NE:
                                    cls = CL_BIN;
                    OP_PLUS_UCONST: cls = CL_PLUSU;
                    OP_STACK_VALUE: cls = CL_STACKVAL;
                    OP_NOP:         cls = CL_NOP;
                    default:        cls = CL_UNSUP;
                endcase
            end
            return cls;
        end
    endfunction

    // Number of live entries an operation needs.
    function automatic logic [1:0] f_need(input t_opclass cls);
        logic [1:0] n;
        begin
            case (cls)
                CL_DROP, CL_DUP, CL_ABS, CL_NEG, CL_PLUSU, CL_STACKVAL: n = 2'd1;
                CL_OVER, CL_SWAP, CL_BIN:                                n = 2'd2;
                CL_ROT:                                                  n = 2'd3;
                default:                                                 n = 2'd0;
            endcase
            return n;
        end
    endfunction

endpackage

FILE: hw/rtl/dwe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dwe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/dwe_div.sv
// Restoring unsigned 64-bit divider, one quotient bit per cycle.
// No dependencies.
module dwe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);
    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_dsr, n_dsr;
    logic [64:0] w_sh;
    logic [64:0] w_diff;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        w_sh   = {r_rem, r_quo[63]};
        w_diff = w_sh - {1'b0, r_dsr};
        o_done = r_busy && (r_cnt == 7'd0);
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd64;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (r_cnt == 7'd0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 7'd1;
                if (!w_diff[64]) begin
                    n_rem = w_diff[63:0];
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = w_sh[63:0];
                    n_quo = {r_quo[62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_quotient = r_quo;
endmodule

FILE: hw/rtl/dwe_mul.sv
// Sequential 64-bit multiplier giving the low 64 bits of the product,
// built on one 32 by 32 multiplier used for three partial products. No dependencies.
module dwe_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_product
);
    logic        r_busy, n_busy;
    logic [2:0]  r_cnt, n_cnt;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_p, n_p;
    logic [63:0] r_acc, n_acc;
    logic [31:0] w_x, w_y;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_p    = r_p;
        n_acc  = r_acc;
        o_done = r_busy && (r_cnt == 3'd4);
        case (r_cnt)
            3'd0:    begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            3'd1:    begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            default: begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
        endcase
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_cnt == 3'd4) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt != 3'd3) begin
                    n_p = {32'd0, w_x} * {32'd0, w_y};
                end
                if (r_cnt == 3'd1) begin
                    n_acc = r_acc + r_p;
                end else if (r_cnt != 3'd0) begin
                    n_acc = r_acc + {r_p[31:0], 32'd0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_p   <= n_p;
        r_acc <= n_acc;
    end

    assign o_product = r_acc;
endmodule

FILE: hw/rtl/dwarf_expression_stack_machine.sv
// Top level of the DWARF expression stack machine: sequencer, stack RAM and arithmetic units.
// Depends on dwe_pkg, dwe_ram, dwe_div and dwe_mul.
//
// Each input word carries one DW_OP opcode with its decoded operand and is executed
// against a stack held in a RAM with a registered read; the top entry is also kept in
// a register. One operation at a time is in flight. Over, pick, drop, swap, rot and
// binary ops first read an entry from the RAM, and rot also reads a third entry; swap
// and rot write their deeper entries in a further step, and mul and div wait in their
// own state for the shared 32 by 32 multiplier (three partial products) or the divider
// (one quotient bit per cycle). A word that raises an error, and every later word of
// the same expression, goes straight from decode to the finish step. A word marked
// last yields one result word, held in an output register, and the stack is then
// emptied; a last word also waits until an earlier result has been taken, while other
// operations may be accepted as that result waits.
// There is no clearing pass after reset.
module dwarf_expression_stack_machine #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_mode,
    input  logic [63:0] i_operand,
    input  logic        i_last_op,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_value,
    output logic [2:0]  o_error_code
);
    import dwe_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    t_state         r_state, n_state;
    logic [7:0]     r_mode, n_mode;
    logic [63:0]    r_operand, n_operand;
    logic           r_last, n_last;
    logic [SPW-1:0] r_sp, n_sp;
    logic [63:0]    r_top, n_top;
    logic [63:0]    r_a, n_a;
    logic [63:0]    r_b, n_b;
    logic [63:0]    r_c, n_c;
    logic [63:0]    r_latch, n_latch;
    logic           r_flag, n_flag;
    logic [2:0]     r_err, n_err;
    logic           r_ovalid, n_ovalid;
    logic [63:0]    r_oval, n_oval;
    logic [2:0]     r_oerr, n_oerr;

    t_opclass       w_cls;
    logic           w_we;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [63:0]    w_wdata, w_rdata, w_res, w_quo, w_prod;
    logic           w_div_start, w_mul_start, w_div_done, w_mul_done;
    logic [SPW-1:0] w_sp_m1, w_sp_m2, w_sp_m3, w_pick;
    logic           w_under, w_over;

    dwe_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dwe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_b),
        .i_divisor  (r_a),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    dwe_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (r_a),
        .i_b       (r_b),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    assign w_cls   = f_classify(r_mode);
    assign w_sp_m1 = r_sp - SPW'(1);
    assign w_sp_m2 = r_sp - SPW'(2);
    assign w_sp_m3 = r_sp - SPW'(3);
    assign w_pick  = w_sp_m1 - r_operand[SPW-1:0];
    assign w_under = ({{(SPW-2){1'b0}}, f_need(w_cls)} > r_sp)
                  || (w_cls == CL_PICK && r_operand >= 64'(r_sp));
    assign w_over  = (r_sp == SP_FULL) && (w_cls == CL_LIT || w_cls == CL_OPND
                  || w_cls == CL_DUP || w_cls == CL_PICK || w_cls == CL_OVER);
    assign o_stall = (r_state != ST_IDLE);

    // Binary results other than mul and div; a is the top, b the entry below.
    always_comb begin
        case (r_mode)
            OP_AND:   w_res = r_b & r_a;
            OP_OR:    w_res = r_b | r_a;
            OP_XOR:   w_res = r_b ^ r_a;
            OP_SHL:   w_res = (r_a >= 64'd64) ? 64'd0 : (r_b << r_a[5:0]);
            OP_SHR:   w_res = (r_a >= 64'd64) ? 64'd0 : (r_b >> r_a[5:0]);
            OP_PLUS:  w_res = r_b + r_a;
            OP_MINUS: w_res = r_b - r_a;
            OP_LT:    w_res = {63'd0, $signed(r_b) <  $signed(r_a)};
            OP_LE:    w_res = {63'd0, $signed(r_b) <= $signed(r_a)};
            OP_GT:    w_res = {63'd0, $signed(r_b) >  $signed(r_a)};
            OP_GE:    w_res = {63'd0, $signed(r_b) >= $signed(r_a)};
            OP_EQ:    w_res = {63'd0, r_b == r_a};
            default:  w_res = {63'd0, r_b != r_a};
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_operand = r_operand;
        n_last    = r_last;
        n_sp      = r_sp;
        n_top     = r_top;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_latch   = r_latch;
        n_flag    = r_flag;
        n_err     = r_err;
        n_ovalid  = r_ovalid && i_stall;
        n_oval    = r_oval;
        n_oerr    = r_oerr;
        w_we        = 1'b0;
        w_waddr     = w_sp_m1[AW-1:0];
        w_wdata     = r_top;
        w_raddr     = w_sp_m2[AW-1:0];
        w_div_start = 1'b0;
        w_mul_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_mode    = i_mode;
                    n_operand = i_operand;
                    n_last    = i_last_op;
                    n_state   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_a = r_top;
                if (w_cls == CL_PICK) begin
                    w_raddr = w_pick[AW-1:0];
                end
                if (r_err != ERR_OK) begin
                    n_state = ST_FIN;
                end else if (w_cls == CL_UNSUP) begin
                    n_err   = ERR_UNSUP;
                    n_state = ST_FIN;
                end else if (w_under) begin
                    n_err   = ERR_UNDER;
                    n_state = ST_FIN;
                end else if (w_over) begin
                    n_err   = ERR_OVER;
                    n_state = ST_FIN;
                end else if (r_mode == OP_DIV && r_top == 64'd0) begin
                    n_err   = ERR_DIV0;
                    n_state = ST_FIN;
                end else if (w_cls == CL_PICK || w_cls == CL_OVER || w_cls == CL_SWAP
                          || w_cls == CL_ROT || w_cls == CL_BIN || w_cls == CL_DROP) begin
                    n_state = ST_RD1;
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_RD1: begin
                n_b     = w_rdata;
                w_raddr = w_sp_m3[AW-1:0];
                n_state = (w_cls == CL_ROT) ? ST_RD2 : ST_EXEC;
            end
            ST_RD2: begin
                n_c     = w_rdata;
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_FIN;
                case (w_cls)
                    CL_LIT, CL_OPND, CL_DUP, CL_PICK, CL_OVER: begin
                        w_we    = 1'b1;
                        w_waddr = r_sp[AW-1:0];
                        case (w_cls)
                            CL_LIT:  w_wdata = {56'd0, r_mode - OP_LIT0};
                            CL_OPND: w_wdata = r_operand;
                            CL_DUP:  w_wdata = r_a;
                            default: w_wdata = r_b;
                        endcase
                        n_top = w_wdata;
                        n_sp  = r_sp + SPW'(1);
                    end
                    CL_DROP: begin
                        n_top = r_b;
                        n_sp  = w_sp_m1;
                    end
                    CL_SWAP, CL_ROT: begin
                        // The new top goes out now; the deeper entries follow.
                        w_we    = 1'b1;
                        w_wdata = r_b;
                        n_top   = r_b;
                        n_state = ST_WR2;
                    end
                    CL_ABS, CL_NEG, CL_PLUSU: begin
                        w_we = 1'b1;
                        if (w_cls == CL_PLUSU) begin
                            w_wdata = r_a + r_operand;
                        end else if (w_cls == CL_NEG || r_a[63]) begin
                            w_wdata = 64'd0 - r_a;
                        end else begin
                            w_wdata = r_a;
                        end
                        n_top = w_wdata;
                    end
                    CL_BIN: begin
                        if (r_mode == OP_DIV) begin
                            w_div_start = 1'b1;
                            n_state     = ST_MULDIV;
                        end else if (r_mode == OP_MUL) begin
                            w_mul_start = 1'b1;
                            n_state     = ST_MULDIV;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_sp_m2[AW-1:0];
                            w_wdata = w_res;
                            n_top   = w_res;
                            n_sp    = w_sp_m1;
                        end
                    end
                    CL_STACKVAL: begin
                        n_latch = r_a;
                        n_flag  = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_MULDIV: begin
                if (w_div_done || w_mul_done) begin
                    w_we    = 1'b1;
                    w_waddr = w_sp_m2[AW-1:0];
                    w_wdata = w_div_done ? w_quo : w_prod;
                    n_top   = w_wdata;
                    n_sp    = w_sp_m1;
                    n_state = ST_FIN;
                end
            end
            ST_WR2: begin
                // Rot needs a third write, which is done with r_c moved down.
                w_we    = 1'b1;
                w_waddr = w_sp_m2[AW-1:0];
                if (w_cls == CL_SWAP) begin
                    w_wdata = r_a;
                    n_state = ST_FIN;
                end else begin
                    w_wdata = r_c;
                    n_c     = r_a;
                    n_mode  = OP_SWAP;
                    n_state = ST_FIN;
                    w_we    = 1'b1;
                end
                if (w_cls == CL_ROT) begin
                    n_state = ST_WR2;
                    n_sp    = w_sp_m1;
                    n_a     = r_a;
                end
            end
            ST_FIN: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (!(r_ovalid && i_stall)) begin
                    n_ovalid = 1'b1;
                    n_oerr   = r_err;
                    n_oval   = 64'd0;
                    if (r_err == ERR_OK) begin
                        if (r_flag) begin
                            n_oval = r_latch;
                        end else if (r_sp != '0) begin
                            n_oval = r_top;
                        end else begin
                            n_oerr = ERR_UNDER;
                        end
                    end
                    n_sp    = '0;
                    n_latch = 64'd0;
                    n_flag  = 1'b0;
                    n_err   = ERR_OK;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Rot is finished as a swap one entry lower; the pointer is restored afterwards.
    logic r_rot_fix, n_rot_fix;
    always_comb begin
        n_rot_fix = r_rot_fix;
        if (r_state == ST_WR2 && w_cls == CL_ROT) begin
            n_rot_fix = 1'b1;
        end else if (r_state == ST_FIN) begin
            n_rot_fix = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= '0;
            r_latch   <= '0;
            r_flag    <= 1'b0;
            r_err     <= ERR_OK;
            r_ovalid  <= 1'b0;
            r_rot_fix <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= (r_state == ST_FIN && r_rot_fix && !r_last) ? r_sp + SPW'(1)
                       : (r_state == ST_FIN && r_rot_fix && (r_ovalid && i_stall))
                         ? r_sp + SPW'(1) : n_sp;
            r_latch   <= n_latch;
            r_flag    <= n_flag;
            r_err     <= n_err;
            r_ovalid  <= n_ovalid;
            r_rot_fix <= (r_state == ST_FIN && !(r_last && r_ovalid && i_stall)) ? 1'b0
                       : (r_state == ST_FIN) ? 1'b0 : n_rot_fix;
        end
        r_mode    <= n_mode;
        r_operand <= n_operand;
        r_last    <= n_last;
        r_top     <= n_top;
        r_a       <= n_a;
        r_b       <= (r_state == ST_WR2 && w_cls == CL_ROT) ? r_c : n_b;
        r_c       <= n_c;
        r_oval    <= n_oval;
        r_oerr    <= n_oerr;
    end

    assign o_valid      = r_ovalid;
    assign o_value      = r_oval;
    assign o_error_code = r_oerr;
endmodule
